// File: hdl/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg
// Shared types, codes and constants of the joint histogram engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mch_pkg;

    localparam int STORE_DEPTH_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int MAX_CHANNELS_DEF = 2;

    localparam int SAMPLE_W  = 16;
    localparam int BUCKET_W  = 13;
    localparam int BIN_W     = 12;
    localparam int IDX_W     = 24;  // widest combined index before the depth check
    localparam int COUNT_W   = 32;
    localparam int QUO_W     = 29;  // |v-low| * buckets fits in 29 bits
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int TDATA_W   = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DROP = 2'd1;
    localparam logic [1:0] STAT_FLAT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BKT0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BKT1   = 3'd6;

    typedef struct packed {
        logic [1:0]          num_channels;
        logic [SAMPLE_W-1:0] low0;
        logic [SAMPLE_W-1:0] high0;
        logic [BUCKET_W-1:0] bkt0;
        logic [SAMPLE_W-1:0] low1;
        logic [SAMPLE_W-1:0] high1;
        logic [BUCKET_W-1:0] bkt1;
    } cfg_t;

    // One classified command handed from front to back
    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] idx;
        logic             flat;
    } job_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic [BIN_W-1:0]   combined_bin;
        logic [1:0]         status;
    } result_t;

    // Bucket count with zero read as one and anything above 4096 as 4096
    function automatic logic [BUCKET_W-1:0] eff_buckets(input logic [BUCKET_W-1:0] b);
        logic [BUCKET_W-1:0] r;
        r = b;
        if (b == '0)
            r = BUCKET_W'(1);
        else if (b > BUCKET_W'(4096))
            r = BUCKET_W'(4096);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mch_ram.sv
// ----------------------------------------------------------------------------
// mch_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/mch_fifo.sv
// ----------------------------------------------------------------------------
// mch_fifo
// Short job queue between the binning front and the counter back.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mch_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output mch_pkg::job_t      pop_data,
    output logic               empty
);

    mch_pkg::job_t                  q_mem [mch_pkg::QDEPTH];
    logic [mch_pkg::QPTR_W-1:0]     wptr_reg, rptr_reg;
    logic [mch_pkg::QPTR_W:0]       cnt_reg;

    assign full     = (cnt_reg == (mch_pkg::QPTR_W+1)'(mch_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = q_mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            q_mem[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop && !empty)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (mch_pkg::QPTR_W+1)'(push && !full)
                               - (mch_pkg::QPTR_W+1)'(pop && !empty);
        end
    end

endmodule

`default_nettype wire

// File: hdl/mch_front.sv
// ----------------------------------------------------------------------------
// mch_front
// Accepts commands, bins samples with a bit-serial divider, forms the index.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_front #(
    parameter int SAMPLE_BITS  = mch_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_CHANNELS = mch_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mch_pkg::cfg_t                cfg,
    input  wire logic                         enable,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   in_cmd,
    input  wire logic [mch_pkg::SAMPLE_W-1:0] in_s0,
    input  wire logic [mch_pkg::SAMPLE_W-1:0] in_s1,
    input  wire logic [mch_pkg::BIN_W-1:0]    in_rb,
    output logic                              push,
    output mch_pkg::job_t                     push_data,
    input  wire logic                         full
);

    localparam logic [mch_pkg::SAMPLE_W-1:0] SMASK =
        mch_pkg::SAMPLE_W'((32'd1 << SAMPLE_BITS) - 1);
    localparam int SW  = mch_pkg::SAMPLE_W;
    localparam int QW  = mch_pkg::QUO_W;
    localparam int BW  = mch_pkg::BUCKET_W;
    localparam int NW  = mch_pkg::BIN_W;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_PREP = 6'b000010,
        F_DIV  = 6'b000100,
        F_FIN  = 6'b001000,
        F_COMB = 6'b010000,
        F_PUSH = 6'b100000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [SW-1:0]      s0_reg, s1_reg;
    logic [NW-1:0]      rb_reg;
    logic               ch_reg;
    logic               flat_reg;
    logic               zero_reg;
    logic [SW-1:0]      ad_reg;
    logic [SW:0]        rem_reg;
    logic [QW-1:0]      quo_reg;
    logic [4:0]         cnt_reg;
    logic [NW-1:0]      bin0_reg, bin1_reg;
    logic [mch_pkg::IDX_W-1:0] prod_reg;

    logic [SW-1:0]      v_sel, lo_sel, hi_sel;
    logic [BW-1:0]      b_sel, b0_eff;
    logic [SW:0]        diff, den;
    logic [SW-1:0]      adiff, aden;
    logic [SW:0]        rem_sh;
    logic               two_ch;
    logic [NW-1:0]      bmax, bin_fin;

    assign two_ch = (MAX_CHANNELS >= 2) && (cfg.num_channels >= 2'd2);
    assign b0_eff = mch_pkg::eff_buckets(cfg.bkt0);

    always_comb
    begin
        v_sel  = (ch_reg ? s1_reg : s0_reg) & SMASK;
        lo_sel = ch_reg ? cfg.low1  : cfg.low0;
        hi_sel = ch_reg ? cfg.high1 : cfg.high0;
        b_sel  = mch_pkg::eff_buckets(ch_reg ? cfg.bkt1 : cfg.bkt0);
        diff   = {1'b0, v_sel} - {1'b0, lo_sel};
        den    = {1'b0, hi_sel} - {1'b0, lo_sel};
        adiff  = diff[SW] ? SW'(-diff) : diff[SW-1:0];
        aden   = den[SW]  ? SW'(-den)  : den[SW-1:0];
        rem_sh = {rem_reg[SW-1:0], quo_reg[QW-1]};
        bmax   = NW'(b_sel - 1'b1);
        if (zero_reg)
            bin_fin = '0;
        else if (quo_reg > QW'(bmax))
            bin_fin = bmax;
        else
            bin_fin = quo_reg[NW-1:0];
    end

    assign in_ready = (state_reg == F_IDLE) && enable;
    assign push     = (state_reg == F_PUSH) && !full;

    always_comb
    begin
        push_data.cmd  = cmd_reg;
        push_data.flat = flat_reg;
        if (cmd_reg == mch_pkg::CMD_ADD)
            push_data.idx = mch_pkg::IDX_W'(bin0_reg) + prod_reg;
        else
            push_data.idx = mch_pkg::IDX_W'(rb_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
                if (in_valid && in_ready)
                    state_next = (in_cmd == mch_pkg::CMD_ADD) ? F_PREP : F_PUSH;
            F_PREP: state_next = F_DIV;
            F_DIV:  if (cnt_reg == 5'(QW - 1)) state_next = F_FIN;
            F_FIN:  state_next = (!ch_reg && two_ch) ? F_PREP : F_COMB;
            F_COMB: state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                cmd_reg  <= in_cmd;
                s0_reg   <= in_s0;
                s1_reg   <= in_s1;
                rb_reg   <= in_rb;
                ch_reg   <= 1'b0;
                flat_reg <= 1'b0;
                bin1_reg <= '0;
            end
            F_PREP:
            begin
                // hold the dividend in the quotient register, shifted out as it divides
                quo_reg  <= QW'(adiff * b_sel);
                ad_reg   <= aden;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                zero_reg <= (den == '0) || (diff == '0) || (diff[SW] != den[SW]);
                if (den == '0)
                    flat_reg <= 1'b1;
            end
            F_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_sh >= {1'b0, ad_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, ad_reg};
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
            end
            F_FIN:
            begin
                if (ch_reg)
                    bin1_reg <= bin_fin;
                else
                    bin0_reg <= bin_fin;
                ch_reg <= 1'b1;
            end
            F_COMB:
                prod_reg <= mch_pkg::IDX_W'(b0_eff * bin1_reg);
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/mch_back.sv
// ----------------------------------------------------------------------------
// mch_back
// Counter store: clearing sweep, saturating update, read, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_back #(
    parameter int STORE_DEPTH = mch_pkg::STORE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mch_pkg::job_t job,
    input  wire logic          job_avail,
    output logic               pop,
    output logic               init_done,
    output logic               out_valid,
    input  wire logic          out_ready,
    output mch_pkg::result_t   out_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = mch_pkg::COUNT_W;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_WAIT  = 4'b0100,
        B_DATA  = 4'b1000
    } bstate_t;

    bstate_t          state_reg;
    logic [AW-1:0]    sweep_reg;
    logic             emit_reg;
    logic             init_reg;
    mch_pkg::job_t    cur_reg;
    logic             out_valid_reg;
    mch_pkg::result_t out_reg;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [CW-1:0]    ram_wdata, ram_rdata, cnt_inc;
    logic             beyond;

    assign beyond    = ({1'b0, job.idx} >= (mch_pkg::IDX_W+1)'(STORE_DEPTH));
    assign pop       = (state_reg == B_IDLE) && job_avail && !out_valid_reg;
    assign ram_re    = pop;
    assign cnt_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
    assign ram_we    = (state_reg == B_CLEAR) ||
                       ((state_reg == B_DATA) && (cur_reg.cmd == mch_pkg::CMD_ADD));
    assign ram_waddr = (state_reg == B_CLEAR) ? sweep_reg : cur_reg.idx[AW-1:0];
    assign ram_wdata = (state_reg == B_CLEAR) ? '0 : cnt_inc;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign init_done = init_reg;

    mch_ram #(.WIDTH(CW), .DEPTH(STORE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (job.idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            sweep_reg     <= '0;
            emit_reg      <= 1'b0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_CLEAR:
                begin
                    if (sweep_reg == AW'(STORE_DEPTH - 1))
                    begin
                        sweep_reg <= '0;
                        init_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                        if (emit_reg)
                            out_valid_reg <= 1'b1;
                    end
                    else
                        sweep_reg <= sweep_reg + 1'b1;
                end
                B_IDLE:
                    if (pop)
                    begin
                        case (job.cmd)
                            mch_pkg::CMD_CLEAR:
                            begin
                                emit_reg  <= 1'b1;
                                state_reg <= B_CLEAR;
                            end
                            mch_pkg::CMD_ADD, mch_pkg::CMD_READ:
                                if (beyond)
                                    out_valid_reg <= 1'b1;
                                else
                                    state_reg <= B_WAIT;
                            default:
                                out_valid_reg <= 1'b1;
                        endcase
                    end
                B_WAIT: state_reg <= B_DATA;
                B_DATA:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg           <= job;
            out_reg.bin_count <= '0;
            out_reg.status    <= (beyond && (job.cmd == mch_pkg::CMD_ADD ||
                                             job.cmd == mch_pkg::CMD_READ)) ?
                                 mch_pkg::STAT_DROP : mch_pkg::STAT_OK;
            out_reg.combined_bin <= (job.cmd == mch_pkg::CMD_READ) ?
                                    job.idx[mch_pkg::BIN_W-1:0] : '0;
        end
        else if (state_reg == B_DATA)
        begin
            out_reg.combined_bin <= cur_reg.idx[mch_pkg::BIN_W-1:0];
            if (cur_reg.cmd == mch_pkg::CMD_ADD)
            begin
                out_reg.bin_count <= cnt_inc;
                out_reg.status    <= cur_reg.flat ? mch_pkg::STAT_FLAT : mch_pkg::STAT_OK;
            end
            else
            begin
                out_reg.bin_count <= ram_rdata;
                out_reg.status    <= mch_pkg::STAT_OK;
            end
        end
    end

    a_pop_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !out_valid_reg)
        else $error("job taken while result slot occupied");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == B_CLEAR || state_reg == B_DATA))
        else $error("counter write outside sweep or update");

    a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DATA |=> out_valid_reg)
        else $error("update finished without a result");

    a_wait_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WAIT |=> state_reg == B_DATA)
        else $error("read data step skipped");

endmodule

`default_nettype wire

// File: hdl/multichannel_histogram_top.sv
// ----------------------------------------------------------------------------
// multichannel_histogram_top
// Joint histogram engine over one or two sample channels.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake         | contents
//  s_*       | in        | s_tvalid/s_tready | cmd, sample_ch0, sample_ch1, read_bin
//  m_*       | out       | m_tvalid/m_tready | bin_count, combined_bin, status
//  cfg_*     | in        | cfg_we            | register index and write data
//
//  An add runs the front through a 29-step bit-serial divider for each active
//  channel; read and other commands skip the divider. The back reads and
//  updates the counter for an add or read; clear walks the whole store. After
//  reset the same clearing pass runs and s_tready stays low until it ends. A
//  four-entry job queue lets the front keep binning while the result register
//  waits on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_histogram_top #(
    parameter int STORE_DEPTH  = mch_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS  = mch_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_CHANNELS = mch_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // cmd[1:0], sample_ch0[17:2], sample_ch1[33:18], read_bin[45:34], zero fill
    input  wire logic [mch_pkg::TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // bin_count[31:0], combined_bin[43:32], status[45:44], zero fill
    output logic [mch_pkg::TDATA_W-1:0]        m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [mch_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mch_pkg::SAMPLE_W-1:0]  cfg_wdata
);

    mch_pkg::cfg_t    cfg_reg;
    mch_pkg::job_t    push_data, pop_data;
    mch_pkg::result_t res;
    logic             push, full, pop, empty, init_done;

    // Config registers; the user writes only while the engine is idle; unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels <= 2'd1;
            cfg_reg.low0         <= '0;
            cfg_reg.high0        <= 16'd255;
            cfg_reg.bkt0         <= 13'd256;
            cfg_reg.low1         <= '0;
            cfg_reg.high1        <= 16'd255;
            cfg_reg.bkt1         <= 13'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mch_pkg::REG_NUM_CH: cfg_reg.num_channels <= cfg_wdata[1:0];
                mch_pkg::REG_LOW0:   cfg_reg.low0         <= cfg_wdata;
                mch_pkg::REG_HIGH0:  cfg_reg.high0        <= cfg_wdata;
                mch_pkg::REG_BKT0:   cfg_reg.bkt0         <= cfg_wdata[12:0];
                mch_pkg::REG_LOW1:   cfg_reg.low1         <= cfg_wdata;
                mch_pkg::REG_HIGH1:  cfg_reg.high1        <= cfg_wdata;
                mch_pkg::REG_BKT1:   cfg_reg.bkt1         <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // Front: take the transaction, bin each active channel, queue the job
    mch_front #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .enable    (init_done),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[1:0]),
        .in_s0     (s_tdata[17:2]),
        .in_s1     (s_tdata[33:18]),
        .in_rb     (s_tdata[45:34]),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mch_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Back: update or read the counter store and hold the result
    mch_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (pop_data),
        .job_avail (!empty),
        .pop       (pop),
        .init_done (init_done),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {2'b00, res.status, res.combined_bin, res.bin_count};

endmodule

`default_nettype wire
